// ===== design/pnm_pkg.sv =====
// ----------------------------------------------------------------------------
// PNM header parser package
// Shared types, codes and character constants for the binary PGM/PPM
// header parser.
// ----------------------------------------------------------------------------
package pnm_pkg;

    // Default parameter values
    localparam int unsigned DIM_BITS_DEF   = 16;
    localparam int unsigned COUNT_BITS_DEF = 16;

    // Parser phase
    typedef enum logic [3:0] {
        PH_IDLE,
        PH_MAGIC,
        PH_WIDTH,
        PH_HEIGHT,
        PH_MAXVAL
    } phase_t;

    // Result status codes
    typedef logic [1:0] status_t;
    localparam status_t ST_OK        = 2'd0;
    localparam status_t ST_BAD_MAGIC = 2'd1;
    localparam status_t ST_BAD_VALUE = 2'd2;
    localparam status_t ST_TOO_LARGE = 2'd3;

    // Component counts
    localparam logic [1:0] COMP_NONE   = 2'd0;
    localparam logic [1:0] COMP_GREY   = 2'd1;
    localparam logic [1:0] COMP_COLOUR = 2'd3;

    // Characters of interest
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_FIVE  = 8'h35;
    localparam logic [7:0] CH_SIX   = 8'h36;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_P     = 8'h50;

    // Only accepted maxval
    localparam logic [15:0] MAXVAL_REQ = 16'd255;

endpackage

// ===== design/pnm_stream_if.sv =====
// ----------------------------------------------------------------------------
// PNM header parser channels
// Valid/ready interfaces for the file byte stream and the header result.
// ----------------------------------------------------------------------------
interface pnm_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       first_byte;

    modport source (output valid, output in_byte, output first_byte, input ready);
    modport sink   (input valid, input in_byte, input first_byte, output ready);
endinterface

interface pnm_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [1:0]  components;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic [17:0] samples_per_line;
    logic [15:0] header_length;

    modport source (
        output valid, output status, output components, output image_width,
        output image_height, output samples_per_line, output header_length,
        input ready
    );
    modport sink (
        input valid, input status, input components, input image_width,
        input image_height, input samples_per_line, input header_length,
        output ready
    );
endinterface

// ===== design/pnm_header_parser.sv =====
// ----------------------------------------------------------------------------
// PNM header parser
// Parses the header of a binary PGM (P5) or PPM (P6) file one byte at a
// time and reports dimensions, components and header length, or an error.
// ----------------------------------------------------------------------------
//  channel | direction | transaction
//  --------+-----------+---------------------------------------------------
//  data    | in        | one file byte, first_byte restarts the parser
//  result  | out       | status, components, size, samples/line, header len
//
//  One byte per cycle: each byte is decoded and the state updated in the
//  cycle it is accepted, the result lands in the output register.
//  A result is visible the cycle after the byte that produces it.
//  data.ready drops only while a held result is not taken by result.ready.
//  Reset leaves the parser idle; bytes are ignored until first_byte.
// ----------------------------------------------------------------------------
module pnm_header_parser #(
    parameter int unsigned DIM_BITS   = pnm_pkg::DIM_BITS_DEF,
    parameter int unsigned COUNT_BITS = pnm_pkg::COUNT_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    pnm_byte_if.sink     data,
    pnm_result_if.source result
);

    // Largest legal width/height, capped to the 16-bit output fields
    localparam logic [19:0] DIM_LIMIT =
        (DIM_BITS >= 16) ? 20'd65535 : 20'((64'd1 << DIM_BITS) - 64'd1);

    typedef enum logic [1:0] {
        VB_MORE,
        VB_DONE,
        VB_BAD,
        VB_BIG
    } vb_t;

    // State
    pnm_pkg::phase_t        phase_reg, phase_next;
    logic                   comment_reg, comment_next;
    logic                   digit_reg, digit_next;
    logic [15:0]            acc_reg, acc_next;
    logic [1:0]             comp_reg, comp_next;
    logic [15:0]            width_reg, width_next;
    logic [15:0]            height_reg, height_next;
    logic [COUNT_BITS-1:0]  count_reg, count_next;

    // Output register
    logic                   out_valid_reg, out_valid_next;
    pnm_pkg::status_t       status_reg;
    logic [1:0]             comps_reg;
    logic [15:0]            owidth_reg;
    logic [15:0]            oheight_reg;
    logic [17:0]            spl_reg;
    logic [15:0]            hlen_reg;

    // Byte decode
    logic                   accept;
    logic [7:0]             c;
    logic                   is_digit, is_blank, is_hash, is_lf;
    logic [19:0]            acc_wide, acc_mul, limit;
    vb_t                    vb;
    logic                   emit;
    pnm_pkg::status_t       emit_status;
    logic [17:0]            spl_next;
    logic [31:0]            count_ext;

    assign data.ready = !out_valid_reg || result.ready;
    assign accept     = data.valid && data.ready;
    assign c          = data.in_byte;

    assign is_digit = (c >= pnm_pkg::CH_ZERO) && (c <= pnm_pkg::CH_NINE);
    assign is_blank = (c == pnm_pkg::CH_SPACE)
                   || ((c >= pnm_pkg::CH_TAB) && (c <= pnm_pkg::CH_CR));
    assign is_hash  = (c == pnm_pkg::CH_HASH);
    assign is_lf    = (c == pnm_pkg::CH_LF);

    // acc * 10 + digit, digit value is the low nibble of an ASCII digit
    assign acc_wide = {4'b0000, acc_reg};
    assign acc_mul  = (acc_wide << 3) + (acc_wide << 1) + {16'd0, c[3:0]};
    assign limit    = (phase_reg == pnm_pkg::PH_MAXVAL) ? {4'b0000, pnm_pkg::MAXVAL_REQ}
                                                        : DIM_LIMIT;

    // Next state and result
    always_comb
    begin
        phase_next   = phase_reg;
        comment_next = comment_reg;
        digit_next   = digit_reg;
        acc_next     = acc_reg;
        comp_next    = comp_reg;
        width_next   = width_reg;
        height_next  = height_reg;
        count_next   = count_reg;
        vb           = VB_MORE;
        emit         = 1'b0;
        emit_status  = pnm_pkg::ST_OK;

        if (accept)
        begin
            if (data.first_byte)
            begin
                // restart: everything cleared, this byte counted
                phase_next   = pnm_pkg::PH_MAGIC;
                comment_next = 1'b0;
                digit_next   = 1'b0;
                acc_next     = '0;
                comp_next    = pnm_pkg::COMP_NONE;
                width_next   = '0;
                height_next  = '0;
                count_next   = COUNT_BITS'(1);
                if (c != pnm_pkg::CH_P)
                begin
                    emit        = 1'b1;
                    emit_status = pnm_pkg::ST_BAD_MAGIC;
                end
            end
            else if (phase_reg != pnm_pkg::PH_IDLE)
            begin
                if (count_reg != '1)
                    count_next = count_reg + 1'b1;

                unique case (phase_reg)
                    pnm_pkg::PH_MAGIC:
                    begin
                        if (c == pnm_pkg::CH_SIX)
                            comp_next = pnm_pkg::COMP_COLOUR;
                        else if (c == pnm_pkg::CH_FIVE)
                            comp_next = pnm_pkg::COMP_GREY;
                        else
                        begin
                            emit        = 1'b1;
                            emit_status = pnm_pkg::ST_BAD_MAGIC;
                        end
                        phase_next   = pnm_pkg::PH_WIDTH;
                        acc_next     = '0;
                        digit_next   = 1'b0;
                        comment_next = 1'b0;
                    end
                    pnm_pkg::PH_WIDTH, pnm_pkg::PH_HEIGHT, pnm_pkg::PH_MAXVAL:
                    begin
                        // classify the byte within a number field
                        if (comment_reg)
                        begin
                            if (is_lf)
                                comment_next = 1'b0;
                        end
                        else if (is_digit)
                        begin
                            acc_next   = acc_mul[15:0];
                            digit_next = 1'b1;
                            if (acc_mul > limit)
                                vb = VB_BIG;
                        end
                        else if (digit_reg)
                            vb = VB_DONE;
                        else if (is_hash)
                            comment_next = 1'b1;
                        else if (!is_blank)
                            vb = VB_BAD;

                        if (phase_reg == pnm_pkg::PH_MAXVAL)
                        begin
                            // byte ending maxval is the separator
                            if (vb != VB_MORE)
                            begin
                                emit        = 1'b1;
                                emit_status = (vb == VB_DONE && acc_reg == pnm_pkg::MAXVAL_REQ)
                                            ? pnm_pkg::ST_OK : pnm_pkg::ST_BAD_VALUE;
                            end
                        end
                        else
                        begin
                            unique case (vb)
                                VB_MORE:
                                begin
                                    emit = 1'b0;
                                end
                                VB_BIG:
                                begin
                                    emit        = 1'b1;
                                    emit_status = pnm_pkg::ST_TOO_LARGE;
                                end
                                VB_BAD:
                                begin
                                    emit        = 1'b1;
                                    emit_status = pnm_pkg::ST_BAD_VALUE;
                                end
                                VB_DONE:
                                begin
                                    if (acc_reg == '0)
                                    begin
                                        emit        = 1'b1;
                                        emit_status = pnm_pkg::ST_BAD_VALUE;
                                    end
                                    else
                                    begin
                                        if (phase_reg == pnm_pkg::PH_WIDTH)
                                        begin
                                            width_next = acc_reg;
                                            phase_next = pnm_pkg::PH_HEIGHT;
                                        end
                                        else
                                        begin
                                            height_next = acc_reg;
                                            phase_next  = pnm_pkg::PH_MAXVAL;
                                        end
                                        // ending byte reopens the next number
                                        acc_next     = '0;
                                        digit_next   = 1'b0;
                                        comment_next = is_hash;
                                        if (!is_blank && !is_hash)
                                        begin
                                            emit        = 1'b1;
                                            emit_status = pnm_pkg::ST_BAD_VALUE;
                                        end
                                    end
                                end
                            endcase
                        end
                    end
                    default:
                    begin
                        phase_next = pnm_pkg::PH_IDLE;
                    end
                endcase
            end

            if (emit)
                phase_next = pnm_pkg::PH_IDLE;
        end
    end

    // Result fields from the updated state
    assign spl_next  = ({2'b00, width_next} & {18{comp_next[0]}})
                     + ({1'b0, width_next, 1'b0} & {18{comp_next[1]}});
    assign count_ext = 32'(count_next);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept && emit)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= pnm_pkg::PH_IDLE;
            comment_reg   <= 1'b0;
            digit_reg     <= 1'b0;
            acc_reg       <= '0;
            comp_reg      <= pnm_pkg::COMP_NONE;
            width_reg     <= '0;
            height_reg    <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            comment_reg   <= comment_next;
            digit_reg     <= digit_next;
            acc_reg       <= acc_next;
            comp_reg      <= comp_next;
            width_reg     <= width_next;
            height_reg    <= height_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            status_reg  <= emit_status;
            comps_reg   <= comp_next;
            owidth_reg  <= width_next;
            oheight_reg <= height_next;
            spl_reg     <= spl_next;
            hlen_reg    <= (count_ext > 32'd65535) ? 16'hFFFF : count_ext[15:0];
        end
    end

    assign result.valid            = out_valid_reg;
    assign result.status           = status_reg;
    assign result.components       = comps_reg;
    assign result.image_width      = owidth_reg;
    assign result.image_height     = oheight_reg;
    assign result.samples_per_line = spl_reg;
    assign result.header_length    = hlen_reg;

`ifndef NO_ASSERTIONS
    // A good header always carries a known format and non-zero size
    a_ok_complete: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.status == pnm_pkg::ST_OK
        |-> result.components != pnm_pkg::COMP_NONE
            && result.image_width != 16'd0 && result.image_height != 16'd0)
        else $error("ok result with incomplete header fields");

    // A decoded result is presented on the next cycle
    a_emit_shown: assert property (@(posedge clk) disable iff (!rst_n)
        accept && emit |=> result.valid)
        else $error("emitted result not presented");

    // While idle, bytes without a start mark change nothing
    a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !data.first_byte && phase_reg == pnm_pkg::PH_IDLE
        |=> phase_reg == pnm_pkg::PH_IDLE && $stable(count_reg))
        else $error("idle parser reacted to a byte");

    // A grey image has one sample per pixel
    a_grey_samples: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.components == pnm_pkg::COMP_GREY
        |-> result.samples_per_line == {2'b00, result.image_width})
        else $error("samples per line mismatch for grey image");
`endif

endmodule
